FILE: rtl/core/hgr_pkg.sv
// Shared types, codes and character tables for the HTTP GET request router.
// No dependencies; imported by hgr_parse and http_get_request_router_core.
`timescale 1ns / 1ps

package hgr_pkg;

  localparam int unsigned RouteW   = 3;
  localparam int unsigned PathLenW = 12;

  // Route codes on route_code_o
  localparam logic [RouteW-1:0] ROUTE_BAD   = 3'd0;
  localparam logic [RouteW-1:0] ROUTE_ROOT  = 3'd1;
  localparam logic [RouteW-1:0] ROUTE_HELLO = 3'd2;
  localparam logic [RouteW-1:0] ROUTE_STATS = 3'd3;
  localparam logic [RouteW-1:0] ROUTE_NONE  = 3'd4;

  // Parse phases
  localparam logic [1:0] PHASE_METHOD = 2'd0;
  localparam logic [1:0] PHASE_PATH   = 2'd1;
  localparam logic [1:0] PHASE_DONE   = 2'd2;

  localparam int unsigned MinRequestBytes = 14;
  localparam int unsigned MethodLen       = 4;
  localparam int unsigned CandCount       = 3;
  localparam int unsigned CandMaxLen      = 6;
  localparam int unsigned CandIdxW        = 3;

  localparam logic [7:0] CHAR_SPACE = 8'h20;

  typedef struct packed {
    logic                valid;
    logic [RouteW-1:0]   route_code;
    logic [PathLenW-1:0] path_length;
  } hgr_result_t;

  // "GET "
  function automatic logic [7:0] method_char(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0:    c = 8'h47;
      2'd1:    c = 8'h45;
      2'd2:    c = 8'h54;
      default: c = CHAR_SPACE;
    endcase
    return c;
  endfunction

  // Candidate paths: 0 "/", 1 "/hello", 2 "/stats"; unused positions read zero
  function automatic logic [7:0] cand_char(input logic [1:0] cand,
                                           input logic [CandIdxW-1:0] idx);
    logic [7:0] c;
    c = 8'h00;
    if (idx == '0) begin
      c = 8'h2f;
    end else if (cand == 2'd1) begin
      unique case (idx)
        3'd1:    c = 8'h68;
        3'd2:    c = 8'h65;
        3'd3:    c = 8'h6c;
        3'd4:    c = 8'h6c;
        3'd5:    c = 8'h6f;
        default: c = 8'h00;
      endcase
    end else if (cand == 2'd2) begin
      unique case (idx)
        3'd1:    c = 8'h73;
        3'd2:    c = 8'h74;
        3'd3:    c = 8'h61;
        3'd4:    c = 8'h74;
        3'd5:    c = 8'h73;
        default: c = 8'h00;
      endcase
    end
    return c;
  endfunction

  function automatic logic [CandIdxW-1:0] cand_len(input logic [1:0] cand);
    logic [CandIdxW-1:0] n;
    unique case (cand)
      2'd0:    n = 3'd1;
      default: n = 3'd6;
    endcase
    return n;
  endfunction

endpackage

FILE: rtl/core/hgr_parse.sv
// Running parse state for one request: method check, path capture and
// candidate matching. Produces the route on the final beat. Uses hgr_pkg.
`timescale 1ns / 1ps

module hgr_parse import hgr_pkg::*; #(
  parameter int unsigned MAX_REQUEST_BYTES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        beat_i,
  input  logic [7:0]  req_byte_i,
  input  logic        last_byte_i,
  output hgr_result_t result_o
);

  localparam int unsigned CountW = $clog2(MAX_REQUEST_BYTES + 1);

  logic [CountW-1:0]    byte_count_q, byte_count_d;
  logic [CountW-1:0]    path_count_q, path_count_d;
  logic [1:0]           phase_q, phase_d;
  logic                 method_ok_q, method_ok_d;
  logic [CandCount-1:0] match_q, match_d;

  // Updated state after this beat, before the end-of-request clear
  logic [CountW-1:0]    byte_count_n, path_count_n;
  logic [1:0]           phase_n;
  logic                 method_ok_n;
  logic [CandCount-1:0] match_n;
  logic                 in_window;
  logic                 path_short;
  logic [CandIdxW-1:0]  path_idx;

  assign in_window  = byte_count_q < CountW'(MAX_REQUEST_BYTES);
  assign path_short = path_count_q < CountW'(CandMaxLen);
  assign path_idx   = path_short ? path_count_q[CandIdxW-1:0] : '0;

  always_comb begin
    byte_count_n = byte_count_q;
    path_count_n = path_count_q;
    phase_n      = phase_q;
    method_ok_n  = method_ok_q;
    match_n      = match_q;
    if (in_window) begin
      byte_count_n = byte_count_q + 1'b1;
      if (phase_q == PHASE_METHOD) begin
        if (byte_count_q < CountW'(MethodLen) &&
            req_byte_i != method_char(byte_count_q[1:0])) begin
          method_ok_n = 1'b0;
        end
        if (byte_count_q >= CountW'(MethodLen - 1)) begin
          phase_n = PHASE_PATH;
        end
      end else if (phase_q == PHASE_PATH) begin
        if (req_byte_i == CHAR_SPACE) begin
          phase_n = PHASE_DONE;
        end else begin
          for (int i = 0; i < CandCount; i++) begin
            if (!path_short ||
                path_count_q >= CountW'(cand_len(2'(i))) ||
                req_byte_i != cand_char(2'(i), path_idx)) begin
              match_n[i] = 1'b0;
            end
          end
          path_count_n = path_count_q + 1'b1;
        end
      end
    end
  end

  // Route decision on the updated state
  always_comb begin
    result_o.valid       = beat_i && last_byte_i;
    result_o.route_code  = ROUTE_BAD;
    result_o.path_length = '0;
    if (byte_count_n >= CountW'(MinRequestBytes) && method_ok_n &&
        phase_n == PHASE_DONE && path_count_n != '0) begin
      result_o.path_length = PathLenW'(path_count_n);
      priority if (match_n[0] && path_count_n == CountW'(cand_len(2'd0))) begin
        result_o.route_code = ROUTE_ROOT;
      end else if (match_n[1] && path_count_n == CountW'(cand_len(2'd1))) begin
        result_o.route_code = ROUTE_HELLO;
      end else if (match_n[2] && path_count_n == CountW'(cand_len(2'd2))) begin
        result_o.route_code = ROUTE_STATS;
      end else begin
        result_o.route_code = ROUTE_NONE;
      end
    end
  end

  // Clear after the final beat, otherwise advance
  always_comb begin
    byte_count_d = byte_count_q;
    path_count_d = path_count_q;
    phase_d      = phase_q;
    method_ok_d  = method_ok_q;
    match_d      = match_q;
    if (beat_i) begin
      if (last_byte_i) begin
        byte_count_d = '0;
        path_count_d = '0;
        phase_d      = PHASE_METHOD;
        method_ok_d  = 1'b1;
        match_d      = '1;
      end else begin
        byte_count_d = byte_count_n;
        path_count_d = path_count_n;
        phase_d      = phase_n;
        method_ok_d  = method_ok_n;
        match_d      = match_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      path_count_q <= '0;
      phase_q      <= PHASE_METHOD;
      method_ok_q  <= 1'b1;
      match_q      <= '1;
    end else begin
      byte_count_q <= byte_count_d;
      path_count_q <= path_count_d;
      phase_q      <= phase_d;
      method_ok_q  <= method_ok_d;
      match_q      <= match_d;
    end
  end

endmodule

FILE: rtl/core/http_get_request_router_core.sv
// Top level of the HTTP GET request router: byte input channel, parser and
// registered result channel. Depends on hgr_pkg and hgr_parse.
`timescale 1ns / 1ps

// Channel  Direction  Handshake               Payload
// in       input      in_valid_i / in_stall_o   req_byte_i[7:0], last_byte_i
// out      output     out_valid_o / out_stall_i route_code_o[2:0], path_length_o[11:0]
//
// One request byte is taken every cycle while no result is held up.
// The result shows on the output register in the cycle after the final byte.
// in_stall_o rises only while a result waits and out_stall_i is high.
// Reset returns the parser to the start of a request and empties the output.
// Bytes past MAX_REQUEST_BYTES in one request are taken but not parsed.

module http_get_request_router_core import hgr_pkg::*; #(
  parameter int unsigned MAX_REQUEST_BYTES = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          req_byte_i,
  input  logic                last_byte_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [RouteW-1:0]   route_code_o,
  output logic [PathLenW-1:0] path_length_o
);

  logic                beat;
  hgr_result_t         result;
  logic                out_valid_q, out_valid_d;
  logic [RouteW-1:0]   route_code_q;
  logic [PathLenW-1:0] path_length_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign beat       = in_valid_i && !in_stall_o;

  hgr_parse #(
    .MAX_REQUEST_BYTES (MAX_REQUEST_BYTES)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (beat),
    .req_byte_i  (req_byte_i),
    .last_byte_i (last_byte_i),
    .result_o    (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (result.valid) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Load the result on the final beat, hold otherwise
  always_ff @(posedge clk_i) begin
    if (result.valid) begin
      route_code_q  <= result.route_code;
      path_length_q <= result.path_length;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign route_code_o  = route_code_q;
  assign path_length_o = path_length_q;

  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat && last_byte_i |=> out_valid_o)
    else $error("final byte did not produce a result");

  a_bad_has_no_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && route_code_o == ROUTE_BAD |-> path_length_o == '0)
    else $error("bad request carries a path length");

  a_root_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && route_code_o == ROUTE_ROOT |-> path_length_o == PathLenW'(1))
    else $error("root route with wrong path length");

  a_named_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (route_code_o == ROUTE_HELLO || route_code_o == ROUTE_STATS)
    |-> path_length_o == PathLenW'(6))
    else $error("named route with wrong path length");

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> route_code_o <= ROUTE_NONE)
    else $error("route code out of range");

endmodule
